// ===== hw/rtl/pidc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types, widths and constants of the clamped PID controller core.
// ----------------------------------------------------------------------------
package pidc_pkg;

  // field and register widths
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int ACC_W     = 48;
  localparam int DT_W      = 31;
  localparam int GAIN_W    = 32;
  localparam int CFG_IDX_W = 3;

  // multiplier operand split: a wide operand is taken as high and low word
  localparam int OPA_W     = DATA_W + FRAC_BITS + 1;
  localparam int OPL_W     = 32;
  localparam int OPH_W     = OPA_W - OPL_W;
  localparam int MUL_A_W   = OPL_W + 1;
  localparam int PROD_W    = MUL_A_W + GAIN_W;
  localparam int HB_W      = OPH_W + GAIN_W;
  localparam int LW_W      = 64;
  localparam int SUM_W     = 64;
  localparam int HI_SHIFT  = OPL_W - FRAC_BITS;

  // serial divider sizing
  localparam int DIV_MAG_W = OPA_W - 1;
  localparam int DIV_CNT_W = $clog2(DIV_MAG_W + 1);

  // saturation limits
  localparam logic signed [SUM_W-1:0] TERM_LIM  = 64'sd1 <<< 60;
  localparam logic signed [SUM_W-1:0] HB_LIM    = TERM_LIM >>> HI_SHIFT;
  localparam logic signed [SUM_W-1:0] INTEG_MAX = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
  localparam logic signed [SUM_W-1:0] INTEG_MIN = -(64'sd1 <<< (ACC_W - 1));

  // register indexes of the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT,
    REG_TIME_STEP,
    REG_OUTPUT_MAX,
    REG_OUTPUT_MIN,
    REG_GAIN_P,
    REG_GAIN_D,
    REG_GAIN_I
  } cfg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] setpoint;
    logic        [DT_W-1:0]   time_step;
    logic signed [DATA_W-1:0] output_max;
    logic signed [DATA_W-1:0] output_min;
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_d;
    logic signed [GAIN_W-1:0] gain_i;
  } cfg_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_FIX,
    ST_APPLY,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_HI,
    OP_MUL_LO,
    OP_FIX,
    OP_INTEG,
    OP_ACCUM,
    OP_OUT
  } op_t;

  // which term the shared multiplier works on
  typedef enum logic [1:0] {
    SRC_P,
    SRC_INC,
    SRC_I,
    SRC_D
  } src_t;

  typedef struct packed {
    op_t  op;
    src_t src;
    logic div_start;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/pidc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_div
// Restoring serial divider, one quotient bit per cycle, rounds toward zero.
// ----------------------------------------------------------------------------
module pidc_div
  import pidc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [OPA_W-1:0] num,
  input  logic        [DT_W-1:0]  den,
  output logic                    done,
  output logic signed [OPA_W-1:0] quot
);

  logic                   busy;
  logic                   fin;
  logic [DIV_CNT_W-1:0]   cnt;
  logic [DIV_MAG_W-1:0]   n;
  logic [DT_W-1:0]        r;
  logic                   neg;
  logic                   zero;

  logic signed [OPA_W-1:0] num_abs;
  logic        [DT_W:0]    rs;
  logic                    ge;

  // magnitude of the dividend and one trial subtract
  assign num_abs = num[OPA_W-1] ? -num : num;
  assign rs      = {r, n[DIV_MAG_W-1]};
  assign ge      = rs >= {1'b0, den};

  // control of the iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= DIV_CNT_W'(DIV_MAG_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end
    end else if (fin) begin
      fin  <= 1'b0;
      done <= 1'b1;
    end
  end

  // remainder, quotient shift and final sign
  always_ff @(posedge clk) begin
    if (start) begin
      n    <= num_abs[DIV_MAG_W-1:0];
      r    <= '0;
      neg  <= num[OPA_W-1];
      zero <= (den == '0);
    end else if (busy) begin
      if (ge) begin
        r <= DT_W'(rs - {1'b0, den});
        n <= {n[DIV_MAG_W-2:0], 1'b1};
      end else begin
        r <= rs[DT_W-1:0];
        n <= {n[DIV_MAG_W-2:0], 1'b0};
      end
    end else if (fin) begin
      if (zero) begin
        quot <= '0;
      end else if (neg) begin
        quot <= -$signed({1'b0, n});
      end else begin
        quot <= $signed({1'b0, n});
      end
    end
  end

endmodule

// ===== hw/rtl/pidc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_ctrl
// Sequencer: runs the shared multiplier for P, I increment, I and D terms.
// ----------------------------------------------------------------------------
module pidc_ctrl
  import pidc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  src_t   term;
  src_t   term_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      term  <= SRC_P;
    end else begin
      state <= state_next;
      term  <= term_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    term_next  = term;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_MUL_HI;
          term_next  = SRC_P;
        end
      end
      ST_MUL_HI: state_next = ST_MUL_LO;
      ST_MUL_LO: state_next = ST_FIX;
      ST_FIX:    state_next = ST_APPLY;
      ST_APPLY: begin
        case (term)
          SRC_P: begin
            term_next  = SRC_INC;
            state_next = ST_MUL_HI;
          end
          SRC_INC: begin
            term_next  = SRC_I;
            state_next = ST_MUL_HI;
          end
          SRC_I: begin
            term_next  = SRC_D;
            state_next = ST_DIV_WAIT;
          end
          default: state_next = ST_OUT;
        endcase
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          state_next = ST_MUL_HI;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd.op        = OP_NONE;
    cmd.src       = term;
    cmd.div_start = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD;
        end
      end
      ST_MUL_HI: begin
        cmd.op        = OP_MUL_HI;
        cmd.div_start = (term == SRC_P);
      end
      ST_MUL_LO: cmd.op = OP_MUL_LO;
      ST_FIX:    cmd.op = OP_FIX;
      ST_APPLY:  cmd.op = (term == SRC_INC) ? OP_INTEG : OP_ACCUM;
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.op = OP_OUT;
        end
      end
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

// ===== hw/rtl/pidc_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_dpath
// Error, integral and derivative state, shared multiplier, term sum, clamp
// and the output register.
// ----------------------------------------------------------------------------
module pidc_dpath
  import pidc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic signed [DATA_W-1:0] measured_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] control_output
);

  logic signed [DATA_W-1:0] err;
  logic signed [DATA_W-1:0] prev_err;
  logic signed [ACC_W-1:0]  integ;
  logic signed [HB_W-1:0]   hb;
  logic signed [LW_W-1:0]   lw;
  logic signed [SUM_W-1:0]  fix;
  logic signed [SUM_W-1:0]  sum;

  logic signed [DATA_W:0]   diff;
  logic signed [DATA_W-1:0] err_next;
  logic signed [DATA_W:0]   ediff;
  logic signed [OPA_W-1:0]  div_num;
  logic signed [OPA_W-1:0]  deriv;
  logic                     div_done;

  logic signed [OPA_W-1:0]   op_a;
  logic signed [GAIN_W-1:0]  op_b;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [PROD_W-1:0]  mul_prod;

  logic signed [SUM_W-1:0]  hb_ext;
  logic signed [SUM_W-1:0]  part;
  logic signed [SUM_W-1:0]  fix_next;
  logic signed [SUM_W-1:0]  isum;
  logic signed [SUM_W-1:0]  omax;
  logic signed [SUM_W-1:0]  omin;

  // saturated error
  assign diff = DATA_W'(0) + ($signed({cfg.setpoint[DATA_W-1], cfg.setpoint})
              - $signed({measured_value[DATA_W-1], measured_value}));
  always_comb begin
    if (diff[DATA_W] != diff[DATA_W-1]) begin
      err_next = diff[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      err_next = diff[DATA_W-1:0];
    end
  end

  // derivative dividend: change in error scaled by one
  assign ediff   = $signed({err[DATA_W-1], err}) - $signed({prev_err[DATA_W-1], prev_err});
  assign div_num = {ediff, {FRAC_BITS{1'b0}}};

  pidc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (cfg.time_step),
    .done  (div_done),
    .quot  (deriv)
  );

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.src)
      SRC_P: begin
        op_a = OPA_W'(err);
        op_b = cfg.gain_p;
      end
      SRC_INC: begin
        op_a = OPA_W'(err);
        op_b = $signed({1'b0, cfg.time_step});
      end
      SRC_I: begin
        op_a = OPA_W'(integ);
        op_b = cfg.gain_i;
      end
      default: begin
        op_a = deriv;
        op_b = cfg.gain_d;
      end
    endcase
  end

  // high word signed, low word unsigned
  assign mul_a    = (cmd.op == OP_MUL_HI) ? MUL_A_W'($signed(op_a[OPA_W-1:OPL_W]))
                                          : $signed({1'b0, op_a[OPL_W-1:0]});
  assign mul_prod = mul_a * op_b;

  // floor of the scaled product, saturated to the term limit
  assign hb_ext = SUM_W'(hb);
  assign part   = (hb_ext <<< HI_SHIFT) + (lw >>> FRAC_BITS);
  always_comb begin
    if (hb_ext > HB_LIM) begin
      fix_next = TERM_LIM;
    end else if (hb_ext < -HB_LIM) begin
      fix_next = -TERM_LIM;
    end else if (part > TERM_LIM) begin
      fix_next = TERM_LIM;
    end else if (part < -TERM_LIM) begin
      fix_next = -TERM_LIM;
    end else begin
      fix_next = part;
    end
  end

  // saturating integral sum
  assign isum = SUM_W'(integ) + fix;

  // output clamp bounds
  assign omax = SUM_W'(cfg.output_max);
  assign omin = SUM_W'(cfg.output_min);

  // loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      integ    <= '0;
      prev_err <= '0;
    end else begin
      if (cmd.op == OP_INTEG) begin
        if (isum > INTEG_MAX) begin
          integ <= ACC_W'(INTEG_MAX);
        end else if (isum < INTEG_MIN) begin
          integ <= ACC_W'(INTEG_MIN);
        end else begin
          integ <= isum[ACC_W-1:0];
        end
      end
      if (cmd.op == OP_OUT) begin
        prev_err <= err;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        err <= err_next;
        sum <= '0;
      end
      OP_MUL_HI: hb  <= mul_prod[HB_W-1:0];
      OP_MUL_LO: lw  <= mul_prod[LW_W-1:0];
      OP_FIX:    fix <= fix_next;
      OP_ACCUM:  sum <= sum + fix;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      if (sum > omax) begin
        control_output <= cfg.output_max;
      end else if (sum < omin) begin
        control_output <= cfg.output_min;
      end else begin
        control_output <= sum[DATA_W-1:0];
      end
    end
  end

  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid || out_ready;

endmodule

// ===== hw/rtl/pid_controller_clamped_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_clamped_core
// Discrete PID controller with clamped output, signed Q16.16 samples, gains and limits.
// ----------------------------------------------------------------------------
//
//  channel   | direction | payload                          | handshake
//  ----------+-----------+----------------------------------+-----------------
//  s_axis    | in        | measured_value                   | tvalid / tready
//  m_axis    | out       | control_output                   | tvalid / tready
//  cfg       | in        | register index, 32-bit data      | valid / ready
//
// the serial divider for the derivative (start, 48 quotient bits, sign and
// done steps) sets when a result is valid; the shared multiplier runs the
// proportional and integral terms alongside it, and the derivative term
// follows it. the next sample is taken only after the last result has gone
// into the output register and the core is idle again.
// reset clears the registers to their defaults and the integral and last error
// to zero. the result waits in an output register, so a stalled m_axis lets
// the next sample in; only a second result stalls behind it.
// configuration writes are taken in every cycle.
module pid_controller_clamped_core
  import pidc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // measured_value [31:0]
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [DATA_W-1:0]    s_axis_tdata,
  // control_output [31:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [DATA_W-1:0]    m_axis_tdata,
  // configuration write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  logic signed [DATA_W-1:0] control_output;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint   <= '0;
      cfg.time_step  <= DT_W'(1 << FRAC_BITS);
      cfg.output_max <= {1'b0, {(DATA_W-1){1'b1}}};
      cfg.output_min <= {1'b1, {(DATA_W-1){1'b0}}};
      cfg.gain_p     <= '0;
      cfg.gain_d     <= '0;
      cfg.gain_i     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SETPOINT:   cfg.setpoint   <= cfg_data;
        REG_TIME_STEP:  cfg.time_step  <= cfg_data[DT_W-1:0];
        REG_OUTPUT_MAX: cfg.output_max <= cfg_data;
        REG_OUTPUT_MIN: cfg.output_min <= cfg_data;
        REG_GAIN_P:     cfg.gain_p     <= cfg_data;
        REG_GAIN_D:     cfg.gain_d     <= cfg_data;
        REG_GAIN_I:     cfg.gain_i     <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  pidc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  pidc_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .sts            (sts),
    .measured_value ($signed(s_axis_tdata)),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .control_output (control_output)
  );

  assign m_axis_tdata = control_output;

  // one sample at a time: no input beat right after another
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input beat accepted while a sample is in work");

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_OUT) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result written over a pending output beat");

  // the divider starts only right after a sample is taken
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("divider started without a new sample");

endmodule

// ===== verif/pid_drive_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_drive_checker
// Watches the sample, drive and register channels of the clamped PID core.
// It keeps its own copy of the register file, the integral and the last error.
// For every accepted sample it computes the clamped drive value. Each drive
// beat is compared against the oldest computed value.
// ----------------------------------------------------------------------------
module pid_drive_checker
  import pidc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [DATA_W-1:0]    s_axis_tdata,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [DATA_W-1:0]    m_axis_tdata,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   mismatches,
  output int                   pending
);

  localparam int     REPORT_MAX = 10;
  localparam longint TERM_CAP   = 64'sd1 <<< 60;
  localparam longint ERR_HI     = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
  localparam longint ERR_LO     = -ERR_HI - 64'sd1;
  localparam longint INTEG_HI   = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
  localparam longint INTEG_LO   = -INTEG_HI - 64'sd1;

  // shadow register file
  logic signed [DATA_W-1:0] setpoint_q;
  logic        [DT_W-1:0]   time_step_q;
  logic signed [DATA_W-1:0] output_max_q;
  logic signed [DATA_W-1:0] output_min_q;
  logic signed [GAIN_W-1:0] gain_p_q;
  logic signed [GAIN_W-1:0] gain_d_q;
  logic signed [GAIN_W-1:0] gain_i_q;

  // controller state
  longint integ_acc;
  longint last_error;

  // drive values still to come, oldest first
  logic [DATA_W-1:0] expected_drive[$];

  function automatic longint cap_term(longint v);
    if (v > TERM_CAP) return TERM_CAP;
    if (v < -TERM_CAP) return -TERM_CAP;
    return v;
  endfunction

  // floor(a * b / 2^FRAC_BITS), split into high and low words of a
  function automatic longint fix_mul(longint a, longint b);
    longint a_hi, a_lo, hb, hb_cap, lo;
    a_hi   = a >>> 32;
    a_lo   = a & 64'hFFFF_FFFF;
    hb     = a_hi * b;
    hb_cap = TERM_CAP >>> (32 - FRAC_BITS);
    if (hb > hb_cap) return TERM_CAP;
    if (hb < -hb_cap) return -TERM_CAP;
    lo = (a_lo * b) >>> FRAC_BITS;
    return cap_term((hb <<< (32 - FRAC_BITS)) + lo);
  endfunction

  // one controller step: updates integral and last error, gives the drive
  function automatic logic [DATA_W-1:0] pid_drive(logic [DATA_W-1:0] sample);
    longint sp, dt, omax, omin, pv, err, inc, deriv, p_term, i_term, d_term, total;
    sp   = setpoint_q;
    dt   = time_step_q;
    omax = output_max_q;
    omin = output_min_q;
    pv   = $signed(sample);

    err = sp - pv;
    if (err > ERR_HI) err = ERR_HI;
    else if (err < ERR_LO) err = ERR_LO;

    p_term = fix_mul(err, gain_p_q);

    // saturating integral
    inc = fix_mul(err, dt);
    if (inc > 0 && integ_acc > INTEG_HI - inc) integ_acc = INTEG_HI;
    else if (inc < 0 && integ_acc < INTEG_LO - inc) integ_acc = INTEG_LO;
    else integ_acc = integ_acc + inc;
    i_term = fix_mul(integ_acc, gain_i_q);

    // derivative, quotient truncated toward zero, zero for a zero step
    if (dt == 0) deriv = 0;
    else deriv = ((err - last_error) * (64'sd1 <<< FRAC_BITS)) / dt;
    d_term = fix_mul(deriv, gain_d_q);

    // upper clamp wins when the limits cross
    total = p_term + i_term + d_term;
    if (total > omax) total = omax;
    else if (total < omin) total = omin;

    last_error = err;
    return total[DATA_W-1:0];
  endfunction

  function automatic void note_mismatch(string what, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
    mismatches = mismatches + 1;
    if (mismatches <= REPORT_MAX)
      $display("%0t: %s: expected %h got %h", $realtime, what, want, got);
  endfunction

  always @(posedge clk) begin : monitor
    logic [DATA_W-1:0] want;
    if (rst) begin
      setpoint_q   = '0;
      time_step_q  = DT_W'(65536);
      output_max_q = 32'h7FFF_FFFF;
      output_min_q = 32'h8000_0000;
      gain_p_q     = '0;
      gain_d_q     = '0;
      gain_i_q     = '0;
      integ_acc    = 0;
      last_error   = 0;
      expected_drive.delete();
    end else begin
      // drive beat against oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_drive.size() == 0) begin
          note_mismatch("unexpected control_output beat", '0, m_axis_tdata);
        end else begin
          want = expected_drive.pop_front();
          if (m_axis_tdata !== want)
            note_mismatch("control_output mismatch", want, m_axis_tdata);
        end
      end
      // register write beat
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          REG_SETPOINT:   setpoint_q   = cfg_data;
          REG_TIME_STEP:  time_step_q  = cfg_data[DT_W-1:0];
          REG_OUTPUT_MAX: output_max_q = cfg_data;
          REG_OUTPUT_MIN: output_min_q = cfg_data;
          REG_GAIN_P:     gain_p_q     = cfg_data;
          REG_GAIN_D:     gain_d_q     = cfg_data;
          REG_GAIN_I:     gain_i_q     = cfg_data;
          default: ;
        endcase
      end
      // sample beat
      if (s_axis_tvalid && s_axis_tready) begin
        want = pid_drive(s_axis_tdata);
        expected_drive.push_back(want);
      end
    end
    pending <= expected_drive.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the clamped PID controller core.
// A directed part covers the extreme samples, error and integral saturation,
// a zero time step and crossed output limits. Random register settings and
// samples then run under four idling phases, checked by pid_drive_checker.
// ----------------------------------------------------------------------------
module testbench;
  import pidc_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_CYC   = 100;
  localparam int PHASE_ITEMS  = 475;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DATA_W-1:0]    m_axis_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  int mismatches;
  int pending;
  int send_idle  = 0;
  int recv_stall = 0;
  int cycle_count = 0;
  logic [31:0] cur_setpoint = '0;

  pid_controller_clamped_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  pid_drive_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // receiver back-pressure
  initial begin
    forever begin
      @(negedge clk);
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("pid_controller_clamped_core verification failed");
    $finish;
  end

  // one register write beat
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SETPOINT) cur_setpoint = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one sample beat, with random idle cycles ahead of it
  task automatic send_sample(logic [DATA_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // stop sending until every drive beat is back
  task automatic hold_off();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  // core idle: nothing pending and the datapath has run out
  task automatic settle();
    hold_off();
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(9))
      0:       pick_gain = '0;
      1:       pick_gain = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2:       pick_gain = $urandom;
      default: pick_gain = int'($urandom_range(524288)) - 262144;
    endcase
  endfunction

  // bit 31 is random so the write mask on the step register is exercised
  function automatic logic [31:0] pick_step();
    logic [30:0] step;
    case ($urandom_range(19))
      0:       step = '0;
      1:       step = 31'd1;
      2:       step = 31'h7FFF_FFFF;
      3:       step = 31'($urandom);
      default: step = 31'($urandom_range(262144, 256));
    endcase
    return {1'($urandom_range(1)), step};
  endfunction

  function automatic logic [31:0] pick_setpoint();
    case ($urandom_range(9))
      0:       pick_setpoint = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1:       pick_setpoint = $urandom;
      default: pick_setpoint = int'($urandom_range(13107200)) - 6553600;
    endcase
  endfunction

  // mostly near the setpoint, some full range and extremes
  function automatic logic [31:0] pick_sample();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       pick_sample = 32'h7FFF_FFFF;
          1:       pick_sample = 32'h8000_0000;
          2:       pick_sample = '0;
          default: pick_sample = '1;
        endcase
      end
      1, 2:    pick_sample = $urandom;
      default: pick_sample = cur_setpoint + (int'($urandom_range(2097152)) - 1048576);
    endcase
  endfunction

  // new random register set, core idle
  task automatic random_config();
    logic [31:0] hi, lo;
    case ($urandom_range(7))
      0: begin
        hi = 32'h7FFF_FFFF;
        lo = 32'h8000_0000;
      end
      1: begin
        hi = $urandom;
        lo = $urandom;
      end
      default: begin
        hi = $urandom_range(67108864);
        lo = -int'($urandom_range(67108864));
      end
    endcase
    cfg_write(REG_SETPOINT, pick_setpoint());
    cfg_write(REG_TIME_STEP, pick_step());
    cfg_write(REG_OUTPUT_MAX, hi);
    cfg_write(REG_OUTPUT_MIN, lo);
    cfg_write(REG_GAIN_P, pick_gain());
    cfg_write(REG_GAIN_D, pick_gain());
    cfg_write(REG_GAIN_I, pick_gain());
  endtask

  initial begin : stimulus
    int sent, seg, seg_len;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset registers, all gains zero
    send_sample('0);
    settle();

    // unit gains, extremes of the sample, error saturation
    cfg_write(REG_SETPOINT, '0);
    cfg_write(REG_TIME_STEP, 32'h0001_0000);
    cfg_write(REG_OUTPUT_MAX, 32'h7FFF_FFFF);
    cfg_write(REG_OUTPUT_MIN, 32'h8000_0000);
    cfg_write(REG_GAIN_P, 32'h0001_0000);
    cfg_write(REG_GAIN_D, 32'h0001_0000);
    cfg_write(REG_GAIN_I, 32'h0001_0000);
    cfg_write(REG_UNUSED, 32'hDEAD_BEEF);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h0000_0001);
    send_sample(32'hFFFF_FFFF);
    settle();

    // integral runs into its upper limit, then its lower limit
    cfg_write(REG_SETPOINT, 32'h7FFF_FFFF);
    cfg_write(REG_TIME_STEP, 32'h7FFF_FFFF);
    cfg_write(REG_GAIN_P, 32'h7FFF_FFFF);
    cfg_write(REG_GAIN_D, 32'h8000_0000);
    cfg_write(REG_GAIN_I, 32'h7FFF_FFFF);
    repeat (4) send_sample(32'h8000_0000);
    settle();
    cfg_write(REG_SETPOINT, 32'h8000_0000);
    repeat (5) send_sample(32'h7FFF_FFFF);
    settle();

    // zero time step, written with only the masked-off top bit set
    cfg_write(REG_TIME_STEP, 32'h8000_0000);
    send_sample(32'h0000_1234);
    send_sample(32'hFFFF_0000);
    settle();

    // lower limit above upper limit
    cfg_write(REG_TIME_STEP, 32'h0001_0000);
    cfg_write(REG_SETPOINT, '0);
    cfg_write(REG_GAIN_P, 32'h0001_0000);
    cfg_write(REG_GAIN_D, '0);
    cfg_write(REG_GAIN_I, '0);
    cfg_write(REG_OUTPUT_MAX, 32'hFFFF_FF00);
    cfg_write(REG_OUTPUT_MIN, 32'h0000_0100);
    send_sample(32'h0010_0000);
    send_sample(32'hFFF0_0000);
    send_sample(32'hFFFF_FF80);

    // random part in four idling phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle  = 0;
          recv_stall = 0;
        end
        1: begin
          send_idle  = 79;
          recv_stall = 0;
        end
        2: begin
          send_idle  = 0;
          recv_stall = 79;
        end
        default: begin
          send_idle  = 12;
          recv_stall = 12;
        end
      endcase
      sent = 0;
      seg  = 0;
      while (sent < PHASE_ITEMS) begin
        settle();
        random_config();
        seg_len = $urandom_range(80, 20);
        for (int k = 0; k < seg_len; k++) begin
          // in the second segment of a phase the sender pauses mid-segment until the pipe is empty
          if (seg == 1 && k == seg_len / 2) hold_off();
          send_sample(pick_sample());
        end
        sent += seg_len;
        seg++;
      end
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("pid_controller_clamped_core verification clean");
    end else begin
      $display("pid_controller_clamped_core verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/pidc_pkg.sv
hw/rtl/pidc_div.sv
hw/rtl/pidc_ctrl.sv
hw/rtl/pidc_dpath.sv
hw/rtl/pid_controller_clamped_core.sv
verif/pid_drive_checker.sv
verif/testbench.sv
